### rtl/core/tmlr_pkg.sv
package tmlr_pkg;

  localparam int DIM_BITS   = 16;
  localparam int INDEX_BITS = 40;
  localparam int ELEM_BITS  = 64;
  localparam int TILE_BITS  = 6;
  localparam int LG_BITS    = 3;
  localparam int POS_BITS   = DIM_BITS + TILE_BITS;
  localparam int PROD_BITS  = 2 * DIM_BITS;
  localparam int CFG_IDX_BITS = 3;

  typedef logic [DIM_BITS-1:0]   dim_t;
  typedef logic [DIM_BITS:0]     dimx_t;
  typedef logic [POS_BITS-1:0]   pos_t;
  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [TILE_BITS-1:0]  tile_t;
  typedef logic [LG_BITS-1:0]    lg_t;
  typedef logic [PROD_BITS-1:0]  prod_t;
  typedef logic [ELEM_BITS-1:0]  elem_t;

  localparam lg_t TILE_LOG2_MAX = lg_t'(TILE_BITS);

  localparam logic DIR_TO_TILED = 1'b0;
  localparam logic DIR_TO_ROWS  = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DIRECTION   = 3'd0,
    REG_BATCH_COUNT = 3'd1,
    REG_ROW_COUNT   = 3'd2,
    REG_COL_COUNT   = 3'd3,
    REG_TILE_LOG2   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic direction;
    dim_t batch_count;
    dim_t row_count;
    dim_t col_count;
    lg_t  tile_log2;
  } cfg_t;

  typedef struct packed {
    idx_t dest_index;
    logic valid_element;
    logic last;
  } tag_t;

endpackage

### rtl/core/tmlr_addr_gen.sv
module tmlr_addr_gen (
  input  logic           clk,
  input  logic           rst_n,
  input  tmlr_pkg::cfg_t cfg,
  input  logic           clear,
  input  logic           adv,
  output tmlr_pkg::tag_t tag,
  output logic           at_start
);

  tmlr_pkg::dim_t  nb, nh, nw, h1, w1;
  tmlr_pkg::dimx_t h1_sum, w1_sum;
  tmlr_pkg::lg_t   lg;
  logic [tmlr_pkg::LG_BITS:0] lg2;
  tmlr_pkg::tile_t c0m1;
  tmlr_pkg::prod_t prod_r;
  tmlr_pkg::idx_t  batch_size, area, row_step0, blk_step1;
  tmlr_pkg::pos_t  row, col;
  tmlr_pkg::idx_t  inner0, dst0, dst1, base_new;
  logic            valid1;
  logic            col_end, cit_end, row_end, rit_end, cb_end, rb_end, bp_end;
  logic            batch_end;

  tmlr_pkg::dim_t  batch_pos_r, batch_pos_nxt;
  tmlr_pkg::dim_t  row_block_r, row_block_nxt;
  tmlr_pkg::dim_t  col_block_r, col_block_nxt;
  tmlr_pkg::tile_t row_in_tile_r, row_in_tile_nxt;
  tmlr_pkg::tile_t col_in_tile_r, col_in_tile_nxt;
  tmlr_pkg::idx_t  dest_base_r, dest_base_nxt;
  // to tiled: major = matrix base + row-block offset, minor = tile offset in the row block
  // to rows:  major = matrix base + row-block offset, minor = base of the current row
  tmlr_pkg::idx_t  major_r, major_nxt;
  tmlr_pkg::idx_t  minor_r, minor_nxt;

  always_comb begin
    nb = (cfg.batch_count == '0) ? tmlr_pkg::dim_t'(1) : cfg.batch_count;
    nh = (cfg.row_count == '0) ? tmlr_pkg::dim_t'(1) : cfg.row_count;
    nw = (cfg.col_count == '0) ? tmlr_pkg::dim_t'(1) : cfg.col_count;
    lg = (cfg.tile_log2 > tmlr_pkg::TILE_LOG2_MAX) ? tmlr_pkg::TILE_LOG2_MAX : cfg.tile_log2;
    lg2 = {lg, 1'b0};
    c0m1 = ~({tmlr_pkg::TILE_BITS{1'b1}} << lg);
    h1_sum = tmlr_pkg::dimx_t'(nh) + tmlr_pkg::dimx_t'(c0m1);
    w1_sum = tmlr_pkg::dimx_t'(nw) + tmlr_pkg::dimx_t'(c0m1);
    h1 = tmlr_pkg::dim_t'(h1_sum >> lg);
    w1 = tmlr_pkg::dim_t'(w1_sum >> lg);
  end

  // matrix size product, registered; config is stable long before it is needed
  always_ff @(posedge clk) begin
    if (cfg.direction == tmlr_pkg::DIR_TO_ROWS) begin
      prod_r <= tmlr_pkg::prod_t'(nh) * tmlr_pkg::prod_t'(nw);
    end else begin
      prod_r <= tmlr_pkg::prod_t'(h1) * tmlr_pkg::prod_t'(w1);
    end
  end

  always_comb begin
    if (cfg.direction == tmlr_pkg::DIR_TO_ROWS) begin
      batch_size = tmlr_pkg::idx_t'(prod_r);
    end else begin
      batch_size = tmlr_pkg::idx_t'(prod_r) << lg2;
    end
    area      = tmlr_pkg::idx_t'(1) << lg2;
    row_step0 = tmlr_pkg::idx_t'(w1) << lg2;
    blk_step1 = tmlr_pkg::idx_t'(nw) << lg;

    row = (tmlr_pkg::pos_t'(row_block_r) << lg) | tmlr_pkg::pos_t'(row_in_tile_r);
    col = (tmlr_pkg::pos_t'(col_block_r) << lg) | tmlr_pkg::pos_t'(col_in_tile_r);

    inner0 = (tmlr_pkg::idx_t'(row_in_tile_r) << lg) | tmlr_pkg::idx_t'(col_in_tile_r);
    dst0   = major_r + minor_r + inner0;
    valid1 = (row < tmlr_pkg::pos_t'(nh)) && (col < tmlr_pkg::pos_t'(nw));
    dst1   = valid1 ? (minor_r + tmlr_pkg::idx_t'(col)) : '0;

    col_end = col >= tmlr_pkg::pos_t'(nw - 1'b1);
    row_end = row >= tmlr_pkg::pos_t'(nh - 1'b1);
    cit_end = col_in_tile_r >= c0m1;
    rit_end = row_in_tile_r >= c0m1;
    cb_end  = col_block_r >= (w1 - 1'b1);
    rb_end  = row_block_r >= (h1 - 1'b1);
    bp_end  = batch_pos_r >= (nb - 1'b1);
  end

  always_comb begin
    batch_pos_nxt   = batch_pos_r;
    row_block_nxt   = row_block_r;
    col_block_nxt   = col_block_r;
    row_in_tile_nxt = row_in_tile_r;
    col_in_tile_nxt = col_in_tile_r;
    dest_base_nxt   = dest_base_r;
    major_nxt       = major_r;
    minor_nxt       = minor_r;
    batch_end       = 1'b0;
    base_new        = '0;

    if (cfg.direction == tmlr_pkg::DIR_TO_TILED) begin
      if (cit_end || col_end) begin
        col_in_tile_nxt = '0;
        if (col_end) begin
          col_block_nxt = '0;
          minor_nxt     = '0;
          if (row_end) begin
            row_in_tile_nxt = '0;
            row_block_nxt   = '0;
            batch_end       = 1'b1;
          end else if (rit_end) begin
            row_in_tile_nxt = '0;
            row_block_nxt   = row_block_r + 1'b1;
            major_nxt       = major_r + row_step0;
          end else begin
            row_in_tile_nxt = row_in_tile_r + 1'b1;
          end
        end else begin
          col_block_nxt = col_block_r + 1'b1;
          minor_nxt     = minor_r + area;
        end
      end else begin
        col_in_tile_nxt = col_in_tile_r + 1'b1;
      end
    end else begin
      if (cit_end) begin
        col_in_tile_nxt = '0;
        if (rit_end) begin
          row_in_tile_nxt = '0;
          if (cb_end) begin
            col_block_nxt = '0;
            if (rb_end) begin
              row_block_nxt = '0;
              batch_end     = 1'b1;
            end else begin
              row_block_nxt = row_block_r + 1'b1;
              major_nxt     = major_r + blk_step1;
              minor_nxt     = major_r + blk_step1;
            end
          end else begin
            col_block_nxt = col_block_r + 1'b1;
            minor_nxt     = major_r;
          end
        end else begin
          row_in_tile_nxt = row_in_tile_r + 1'b1;
          minor_nxt       = minor_r + tmlr_pkg::idx_t'(nw);
        end
      end else begin
        col_in_tile_nxt = col_in_tile_r + 1'b1;
      end
    end

    if (batch_end) begin
      if (bp_end) begin
        batch_pos_nxt = '0;
        base_new      = '0;
      end else begin
        batch_pos_nxt = batch_pos_r + 1'b1;
        base_new      = dest_base_r + batch_size;
      end
      dest_base_nxt = base_new;
      major_nxt     = base_new;
      minor_nxt     = (cfg.direction == tmlr_pkg::DIR_TO_ROWS) ? base_new : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      batch_pos_r   <= '0;
      row_block_r   <= '0;
      col_block_r   <= '0;
      row_in_tile_r <= '0;
      col_in_tile_r <= '0;
      dest_base_r   <= '0;
      major_r       <= '0;
      minor_r       <= '0;
    end else if (adv) begin
      batch_pos_r   <= batch_pos_nxt;
      row_block_r   <= row_block_nxt;
      col_block_r   <= col_block_nxt;
      row_in_tile_r <= row_in_tile_nxt;
      col_in_tile_r <= col_in_tile_nxt;
      dest_base_r   <= dest_base_nxt;
      major_r       <= major_nxt;
      minor_r       <= minor_nxt;
    end
  end

  always_comb begin
    tag.dest_index    = (cfg.direction == tmlr_pkg::DIR_TO_ROWS) ? dst1 : dst0;
    tag.valid_element = (cfg.direction == tmlr_pkg::DIR_TO_ROWS) ? valid1 : 1'b1;
    tag.last          = batch_end && bp_end;
    at_start = (batch_pos_r == '0) && (row_block_r == '0) && (col_block_r == '0) &&
               (row_in_tile_r == '0) && (col_in_tile_r == '0) &&
               (dest_base_r == '0) && (major_r == '0) && (minor_r == '0);
  end

endmodule

### rtl/core/tiled_matrix_layout_reorder_core.sv
// channel   direction  handshake           payload
// cfg_      in         cfg_we              cfg_index, cfg_data
// in_       in         in_valid/in_stall   in_value
// out_      out        out_valid/out_stall out_dest_index, out_value_out, out_valid_element,
//                                          out_last
//
// One request per clock while out_stall is low; held in s1, then in the output register.
// Position counters and running index bases advance once per request, no multiply in the loop.
// in_stall rises only when the input register is full and the output register is held.
// rst_n is synchronous; any write to a defined register restarts the tensor.
module tiled_matrix_layout_reorder_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tmlr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [tmlr_pkg::DIM_BITS-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tmlr_pkg::ELEM_BITS-1:0]      in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tmlr_pkg::INDEX_BITS-1:0]     out_dest_index,
  output logic [tmlr_pkg::ELEM_BITS-1:0]      out_value_out,
  output logic                                out_valid_element,
  output logic                                out_last
);

  tmlr_pkg::cfg_t  cfg_r;
  logic            cfg_clear;
  logic            s1_valid_r;
  tmlr_pkg::elem_t s1_value_r;
  logic            out_valid_r;
  tmlr_pkg::tag_t  out_tag_r;
  tmlr_pkg::elem_t out_value_r;
  logic            out_free, s1_adv, in_acc;
  tmlr_pkg::tag_t  gen_tag;
  logic            gen_at_start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction   <= tmlr_pkg::DIR_TO_TILED;
      cfg_r.batch_count <= tmlr_pkg::dim_t'(1);
      cfg_r.row_count   <= tmlr_pkg::dim_t'(1);
      cfg_r.col_count   <= tmlr_pkg::dim_t'(1);
      cfg_r.tile_log2   <= tmlr_pkg::lg_t'(4);
    end else if (cfg_we) begin
      unique case (tmlr_pkg::cfg_reg_t'(cfg_index))
        tmlr_pkg::REG_DIRECTION:   cfg_r.direction   <= cfg_data[0];
        tmlr_pkg::REG_BATCH_COUNT: cfg_r.batch_count <= cfg_data;
        tmlr_pkg::REG_ROW_COUNT:   cfg_r.row_count   <= cfg_data;
        tmlr_pkg::REG_COL_COUNT:   cfg_r.col_count   <= cfg_data;
        tmlr_pkg::REG_TILE_LOG2:   cfg_r.tile_log2   <= cfg_data[tmlr_pkg::LG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_clear = 1'b0;
    if (cfg_we) begin
      unique case (tmlr_pkg::cfg_reg_t'(cfg_index))
        tmlr_pkg::REG_DIRECTION,
        tmlr_pkg::REG_BATCH_COUNT,
        tmlr_pkg::REG_ROW_COUNT,
        tmlr_pkg::REG_COL_COUNT,
        tmlr_pkg::REG_TILE_LOG2: cfg_clear = 1'b1;
        default:                 cfg_clear = 1'b0;
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_value_r <= in_value;
    end
  end

  tmlr_addr_gen u_addr_gen (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .clear    (cfg_clear),
    .adv      (s1_adv),
    .tag      (gen_tag),
    .at_start (gen_at_start)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_tag_r   <= gen_tag;
      out_value_r <= s1_value_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_dest_index    = out_tag_r.dest_index;
  assign out_value_out     = out_value_r;
  assign out_valid_element = out_tag_r.valid_element;
  assign out_last          = out_tag_r.last;

  a_pad_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tag_r.valid_element |-> out_tag_r.dest_index == '0)
    else $error("padding request carries a non-zero index");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with a free slot");

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && gen_tag.last |=> gen_at_start)
    else $error("position not back at origin after last request");

  a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_clear |=> gen_at_start)
    else $error("register write did not restart the tensor");

endmodule
